// ===== rtl/pcbf_pkg.sv =====
// shared types, constants and arithmetic helpers for the colour bleed filter
`default_nettype none

package pcbf_pkg;

	localparam int COEF_W  = 18;
	localparam int STATE_W = 28;
	localparam int ACC_W   = 32;
	localparam int PROD_W  = COEF_W + STATE_W;
	localparam int TERM_W  = PROD_W - 16;
	localparam int LUMA_W  = 25;
	localparam int LEVEL_W = 8;
	localparam int CFG_IDX_W = 3;

	// 255.0 in 16.16
	localparam logic [LUMA_W-1:0] LEVEL_MAX = 25'd16711680;

	// 255 times the luma weights of red, green and blue
	localparam logic [LUMA_W-1:0] Y_RED   = 25'd4996725;
	localparam logic [LUMA_W-1:0] Y_GREEN = 25'd9809850;
	localparam logic [LUMA_W-1:0] Y_BLUE  = 25'd1905105;

	localparam logic signed [COEF_W-1:0] RST_LUMA_TAP0    = 18'sd19195;
	localparam logic signed [COEF_W-1:0] RST_LUMA_TAP1    = 18'sd38390;
	localparam logic signed [COEF_W-1:0] RST_LUMA_TAP2    = 18'sd19195;
	localparam logic signed [COEF_W-1:0] RST_LUMA_FB2     = 18'sd11244;
	localparam logic signed [COEF_W-1:0] RST_CHROMA_GAIN  = 18'sd8961;
	localparam logic signed [COEF_W-1:0] RST_CHROMA_FB    = -18'sd47615;
	localparam logic signed [COEF_W-1:0] RST_GREEN_RED    = -18'sd33358;
	localparam logic signed [COEF_W-1:0] RST_GREEN_BLUE   = 18'sd12714;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LUMA_TAP0,
		REG_LUMA_TAP1,
		REG_LUMA_TAP2,
		REG_LUMA_FB2,
		REG_CHROMA_GAIN,
		REG_CHROMA_FB,
		REG_GREEN_RED,
		REG_GREEN_BLUE
	} reg_idx_t;

	// one multiply-accumulate per step, in issue order
	typedef enum logic [3:0] {
		STEP_Y_TAP0,
		STEP_Y_TAP1,
		STEP_Y_TAP2,
		STEP_Y_FB2,
		STEP_R_X,
		STEP_R_LAST,
		STEP_R_FB,
		STEP_B_X,
		STEP_B_LAST,
		STEP_B_FB,
		STEP_G_RED,
		STEP_G_BLUE
	} step_t;

	localparam logic [3:0] NUM_STEPS = 4'd12;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic  start;
		logic  mul_en;
		step_t mul_step;
		logic  acc_en;
		step_t acc_step;
		logic  finish;
	} cmd_t;

	function automatic logic [LUMA_W-1:0] luma_in(input logic [2:0] bits);
		logic [LUMA_W-1:0] y;
		y = '0;
		if (bits[0]) y = y + Y_RED;
		if (bits[1]) y = y + Y_GREEN;
		if (bits[2]) y = y + Y_BLUE;
		return y;
	endfunction

	function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = (ACC_W'(1) <<< (STATE_W - 1)) - ACC_W'(1);
		lo = -(ACC_W'(1) <<< (STATE_W - 1));
		if (v > hi) return hi[STATE_W-1:0];
		if (v < lo) return lo[STATE_W-1:0];
		return v[STATE_W-1:0];
	endfunction

	function automatic logic [LUMA_W-1:0] clamp_luma(input logic signed [STATE_W-1:0] v);
		if (v < 0) return '0;
		if (v > $signed({3'd0, LEVEL_MAX})) return LEVEL_MAX;
		return v[LUMA_W-1:0];
	endfunction

	function automatic logic [LEVEL_W-1:0] to_level(input logic signed [ACC_W-1:0] v);
		if (v < 0) return '0;
		if (v >= $signed({7'd0, LEVEL_MAX})) return 8'd255;
		return v[23:16];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/pcbf_ctrl.sv =====
// sequencer: accepts a pixel, steps the shared multiplier, hands over the result word
`default_nettype none

module pcbf_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  wire              m_tready,
	output pcbf_pkg::cmd_t   cmd
);
	import pcbf_pkg::*;

	state_t     state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic       m_valid_q, m_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			m_valid_q <= m_valid_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		s_tready     = 1'b0;
		cmd.start    = 1'b0;
		cmd.mul_en   = 1'b0;
		cmd.mul_step = step_t'(cnt_q);
		cmd.acc_en   = 1'b0;
		cmd.acc_step = step_t'(cnt_q - 4'd1);
		cmd.finish   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.start = 1'b1;
					cnt_d     = '0;
					state_d   = ST_RUN;
				end
			end
			ST_RUN: begin
				// issue step cnt, accumulate the product of step cnt-1
				cmd.mul_en = (cnt_q < NUM_STEPS);
				cmd.acc_en = (cnt_q != 4'd0);
				cnt_d      = cnt_q + 4'd1;
				if (cnt_q == NUM_STEPS) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!m_valid_q || m_tready) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		m_valid_d = m_valid_q;
		if (m_valid_q && m_tready) m_valid_d = 1'b0;
		if (cmd.finish) m_valid_d = 1'b1;
	end

	assign m_tvalid = m_valid_q;

endmodule

`default_nettype wire

// ===== rtl/pcbf_datapath.sv =====
// coefficient registers, filter history, shared multiplier, accumulator, output word
`default_nettype none

module pcbf_datapath (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_valid,
	input  wire  [pcbf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [pcbf_pkg::COEF_W-1:0]           cfg_data,
	input  wire  [2:0]                            colour_bits,
	input  wire                                   line_start,
	input  wire  pcbf_pkg::cmd_t                  cmd,
	output logic [3*pcbf_pkg::LEVEL_W-1:0]        out_word
);
	import pcbf_pkg::*;

	logic signed [COEF_W-1:0] tap0_q, tap1_q, tap2_q, fb2_q;
	logic signed [COEF_W-1:0] gain_q, cfb_q, g_red_q, g_blue_q;

	logic [2:0] bits_q;

	logic signed [STATE_W-1:0] lih0_q, lih1_q, loh0_q, loh1_q;
	logic signed [STATE_W-1:0] rdi_q, rdo_q, bdi_q, bdo_q;
	logic [LUMA_W-1:0]         yc_q;
	logic signed [ACC_W-1:0]   green_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [PROD_W-1:0]  prod_s1;
	logic [3*LEVEL_W-1:0]      out_q;

	logic [LUMA_W-1:0]         y_in;
	logic signed [STATE_W-1:0] y_x, r_x, b_x;
	logic signed [COEF_W-1:0]  coef_sel;
	logic signed [STATE_W-1:0] data_sel;
	logic signed [TERM_W-1:0]  term;
	logic signed [ACC_W-1:0]   term_ext, acc_base, acc_sum;
	logic                      first, neg;
	logic signed [STATE_W-1:0] sum_sat;
	logic signed [ACC_W-1:0]   yc_ext;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap0_q   <= RST_LUMA_TAP0;
			tap1_q   <= RST_LUMA_TAP1;
			tap2_q   <= RST_LUMA_TAP2;
			fb2_q    <= RST_LUMA_FB2;
			gain_q   <= RST_CHROMA_GAIN;
			cfb_q    <= RST_CHROMA_FB;
			g_red_q  <= RST_GREEN_RED;
			g_blue_q <= RST_GREEN_BLUE;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_LUMA_TAP0:   tap0_q   <= cfg_data;
				REG_LUMA_TAP1:   tap1_q   <= cfg_data;
				REG_LUMA_TAP2:   tap2_q   <= cfg_data;
				REG_LUMA_FB2:    fb2_q    <= cfg_data;
				REG_CHROMA_GAIN: gain_q   <= cfg_data;
				REG_CHROMA_FB:   cfb_q    <= cfg_data;
				REG_GREEN_RED:   g_red_q  <= cfg_data;
				REG_GREEN_BLUE:  g_blue_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pixel levels and colour differences from the latched bits
	assign y_in = luma_in(bits_q);
	assign y_x  = $signed({3'd0, y_in});
	assign r_x  = $signed({3'd0, (bits_q[0] ? LEVEL_MAX : '0)}) - y_x;
	assign b_x  = $signed({3'd0, (bits_q[2] ? LEVEL_MAX : '0)}) - y_x;

	always_comb begin
		coef_sel = tap0_q;
		data_sel = y_x;
		case (cmd.mul_step)
			STEP_Y_TAP0: begin coef_sel = tap0_q;   data_sel = y_x;    end
			STEP_Y_TAP1: begin coef_sel = tap1_q;   data_sel = lih0_q; end
			STEP_Y_TAP2: begin coef_sel = tap2_q;   data_sel = lih1_q; end
			STEP_Y_FB2:  begin coef_sel = fb2_q;    data_sel = loh1_q; end
			STEP_R_X:    begin coef_sel = gain_q;   data_sel = r_x;    end
			STEP_R_LAST: begin coef_sel = gain_q;   data_sel = rdi_q;  end
			STEP_R_FB:   begin coef_sel = cfb_q;    data_sel = rdo_q;  end
			STEP_B_X:    begin coef_sel = gain_q;   data_sel = b_x;    end
			STEP_B_LAST: begin coef_sel = gain_q;   data_sel = bdi_q;  end
			STEP_B_FB:   begin coef_sel = cfb_q;    data_sel = bdo_q;  end
			STEP_G_RED:  begin coef_sel = g_red_q;  data_sel = rdo_q;  end
			STEP_G_BLUE: begin coef_sel = g_blue_q; data_sel = bdo_q;  end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			bits_q <= colour_bits;
		end
		if (cmd.mul_en) begin
			prod_s1 <= coef_sel * data_sel;
		end
	end

	// floor shift of the product, then add or subtract into the running sum
	assign term     = prod_s1[PROD_W-1:16];
	assign term_ext = ACC_W'(term);

	always_comb begin
		first = cmd.acc_step inside {STEP_Y_TAP0, STEP_R_X, STEP_B_X, STEP_G_RED};
		neg   = cmd.acc_step inside {STEP_Y_FB2, STEP_R_FB, STEP_B_FB, STEP_G_BLUE};
	end

	assign acc_base = first ? '0 : acc_q;
	assign acc_sum  = neg ? (acc_base - term_ext) : (acc_base + term_ext);
	assign sum_sat  = sat_state(acc_sum);

	// negated terms close each filter sum
	always_ff @(posedge clk) begin
		if (cmd.acc_en) begin
			acc_q <= acc_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_en && cmd.acc_step == STEP_Y_FB2) begin
			yc_q <= clamp_luma(sum_sat);
		end
		if (cmd.acc_en && cmd.acc_step == STEP_G_BLUE) begin
			green_q <= acc_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lih0_q <= '0;
			lih1_q <= '0;
			loh0_q <= '0;
			loh1_q <= '0;
			rdi_q  <= '0;
			rdo_q  <= '0;
			bdi_q  <= '0;
			bdo_q  <= '0;
		end else if (cmd.start && line_start) begin
			lih0_q <= '0;
			lih1_q <= '0;
			loh0_q <= '0;
			loh1_q <= '0;
			rdi_q  <= '0;
			rdo_q  <= '0;
			bdi_q  <= '0;
			bdo_q  <= '0;
		end else if (cmd.acc_en) begin
			case (cmd.acc_step)
				STEP_Y_FB2: begin
					lih1_q <= lih0_q;
					lih0_q <= y_x;
					loh1_q <= loh0_q;
					loh0_q <= sum_sat;
				end
				STEP_R_FB: begin
					rdi_q <= r_x;
					rdo_q <= sum_sat;
				end
				STEP_B_FB: begin
					bdi_q <= b_x;
					bdo_q <= sum_sat;
				end
				default: ;
			endcase
		end
	end

	assign yc_ext = $signed({7'd0, yc_q});

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q <= {to_level(ACC_W'(bdo_q) + yc_ext),
			          to_level(green_q + yc_ext),
			          to_level(ACC_W'(rdo_q) + yc_ext)};
		end
	end

	assign out_word = out_q;

endmodule

`default_nettype wire

// ===== rtl/pal_colour_bleed_filter_core.sv =====
// colour bleed filter top level: 3-bit rgb pixel in, filtered 8-bit rgb word out
// each pixel is worked through the 12 multiply-accumulate steps of one shared 18x28 multiplier;
//   the registered result word and m_tvalid follow once the output register is free, and only
//   then does s_tready rise for the next pixel
// reset: arst_n clears coefficients to defaults, filter history to zero, no word pending
`default_nettype none

module pal_colour_bleed_filter_core (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [7:0]                        s_tdata,  // [2:0] colour_bits, rest zero
	input  wire                               s_tuser,  // [0] line_start
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [23:0]                       m_tdata,  // [7:0] red, [15:8] green, [23:16] blue
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [pcbf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [pcbf_pkg::COEF_W-1:0]       cfg_data
);
	import pcbf_pkg::*;

	cmd_t cmd;

	assign cfg_ready = 1'b1;

	pcbf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	pcbf_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.colour_bits (s_tdata[2:0]),
		.line_start  (s_tuser),
		.cmd         (cmd),
		.out_word    (m_tdata)
	);

endmodule

`default_nettype wire

// ===== rtl/pcbf_checker.sv =====
// port-level checks for the colour bleed filter, bound to the top level
`default_nettype none

module pcbf_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [23:0] m_tdata
);

	// output word holds while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word dropped or changed while stalled");

	// one pixel at a time: no new word taken right after one is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a pixel is in work");

	// the sequencer is still busy at its last run step
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##13 !s_tready)
		else $error("pixel work ended early");

	// a new result shows up just as the block goes back to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result presented while still busy");

endmodule

bind pal_colour_bleed_filter_core pcbf_checker u_pcbf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/sv/tb_pal_colour_bleed_filter_core.sv =====
// testbench for the colour bleed filter core: predicts every rgb word and checks it
`timescale 1ns / 1ps

module tb_pal_colour_bleed_filter_core;

	import pcbf_pkg::*;

	localparam longint RED_LUMA   = 255 * 19595;
	localparam longint GREEN_LUMA = 255 * 38470;
	localparam longint BLUE_LUMA  = 255 * 7471;
	localparam longint FULL_LEVEL = 255 * 65536;
	localparam longint STATE_HI   = 134217727;
	localparam longint STATE_LO   = -134217728;
	localparam logic [COEF_W-1:0] COEF_MAX = 18'h1FFFF;
	localparam logic [COEF_W-1:0] COEF_MIN = 18'h20000;
	localparam int RANDOM_PIXELS = 1660;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;   // [2:0] colour_bits, rest zero
	logic                 s_tuser = 1'b0; // [0] line_start
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [23:0]          m_tdata;        // [7:0] red, [15:8] green, [23:16] blue
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COEF_W-1:0]    cfg_data = '0;

	pal_colour_bleed_filter_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// coefficient copy, defaults and the set to load next
	logic signed [COEF_W-1:0] coef [8];
	logic signed [COEF_W-1:0] dflt_coef [8];
	logic [COEF_W-1:0]        next_coef [8];

	// filter history: luma x[n-1], x[n-2], y[n-1], y[n-2]; colour differences red 0, blue 1
	longint luma_x [2];
	longint luma_y [2];
	longint diff_x [2];
	longint diff_y [2];

	rgb_t expected_rgb_q [$];

	int mismatches = 0;
	int pixels_sent = 0;
	int line_starts = 0;
	int words_checked = 0;
	int coef_sets = 0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int rx_hold_len = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("timeout: %0d words still pending", expected_rgb_q.size());
		$display("[pal_colour_bleed_filter_core] ERROR");
		$finish;
	end

	function automatic longint scale_q16(input logic signed [COEF_W-1:0] c, input longint v);
		return (longint'(c) * v) >>> 16;
	endfunction

	function automatic longint sat28(input longint v);
		if (v > STATE_HI) return STATE_HI;
		if (v < STATE_LO) return STATE_LO;
		return v;
	endfunction

	function automatic logic [7:0] level_of(input longint v);
		if (v < 0) return 8'd0;
		if (v >= FULL_LEVEL) return 8'd255;
		return 8'(v >>> 16);
	endfunction

	function automatic void clear_history();
		for (int i = 0; i < 2; i++) begin
			luma_x[i] = 0;
			luma_y[i] = 0;
			diff_x[i] = 0;
			diff_y[i] = 0;
		end
	endfunction

	// first-order colour difference filter, k selects red or blue
	function automatic longint diff_filter(input int k, input longint x);
		longint y;
		y = scale_q16(coef[REG_CHROMA_GAIN], x) + scale_q16(coef[REG_CHROMA_GAIN], diff_x[k])
			- scale_q16(coef[REG_CHROMA_FB], diff_y[k]);
		y = sat28(y);
		diff_x[k] = x;
		diff_y[k] = y;
		return y;
	endfunction

	function automatic rgb_t predict_rgb(input logic [2:0] bits, input logic line_start);
		longint y_in;
		longint y_out;
		longint ry;
		longint by;
		rgb_t   r;
		if (line_start)
			clear_history();
		y_in = 0;
		if (bits[0]) y_in += RED_LUMA;
		if (bits[1]) y_in += GREEN_LUMA;
		if (bits[2]) y_in += BLUE_LUMA;
		ry = (bits[0] ? FULL_LEVEL : 0) - y_in;
		by = (bits[2] ? FULL_LEVEL : 0) - y_in;
		y_out = scale_q16(coef[REG_LUMA_TAP0], y_in) + scale_q16(coef[REG_LUMA_TAP1], luma_x[0])
			+ scale_q16(coef[REG_LUMA_TAP2], luma_x[1]) - scale_q16(coef[REG_LUMA_FB2], luma_y[1]);
		y_out = sat28(y_out);
		luma_x[1] = luma_x[0];
		luma_x[0] = y_in;
		luma_y[1] = luma_y[0];
		luma_y[0] = y_out;
		// history keeps the unclamped luma, recombination uses 0..255
		if (y_out > FULL_LEVEL) y_out = FULL_LEVEL;
		if (y_out < 0) y_out = 0;
		ry = diff_filter(0, ry);
		by = diff_filter(1, by);
		r.red   = level_of(ry + y_out);
		r.green = level_of(scale_q16(coef[REG_GREEN_RED], ry)
			- scale_q16(coef[REG_GREEN_BLUE], by) + y_out);
		r.blue  = level_of(by + y_out);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int want, input int got);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t ns: %s mismatch, expected %0d got %0d", $time, what, want, got);
	endtask

	// predictor and checker, sampling the handshakes at each edge
	always @(posedge clk) begin : word_checker
		rgb_t got;
		rgb_t want;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_rgb_q.size() == 0) begin
				report_mismatch("unexpected word, blue/green/red", 0, int'(got));
			end else begin
				want = expected_rgb_q.pop_front();
				words_checked++;
				if (got.red !== want.red)
					report_mismatch("red", int'(want.red), int'(got.red));
				if (got.green !== want.green)
					report_mismatch("green", int'(want.green), int'(got.green));
				if (got.blue !== want.blue)
					report_mismatch("blue", int'(want.blue), int'(got.blue));
			end
		end
		if (s_tvalid && s_tready)
			expected_rgb_q.push_back(predict_rgb(s_tdata[2:0], s_tuser));
		if (cfg_valid && cfg_ready)
			coef[cfg_index] = cfg_data;
	end

	// receiver: random stalls, and on request one long hold-off
	initial begin : word_sink
		int n;
		forever begin
			@(posedge clk);
			if (rx_hold_len > 0) begin
				n = rx_hold_len;
				rx_hold_len = 0;
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				n = $urandom_range(0, 99);
				n = (n < 70) ? $urandom_range(1, 3) : (n < 95) ? $urandom_range(4, 10)
					: $urandom_range(20, 60);
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!tx_idle_on || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// called just after a rising edge; returns at the edge that accepts the word
	task automatic send_pixel(input logic [2:0] bits, input logic line_start);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, bits};
		s_tuser  <= line_start;
		do @(posedge clk); while (!s_tready);
		pixels_sent++;
		if (line_start) line_starts++;
	endtask

	// stop offering and wait for every pending word
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_rgb_q.size() != 0);
	endtask

	// writes all eight coefficients from next_coef, block idle
	task automatic load_coefs();
		cfg_valid <= 1'b1;
		for (int i = 0; i < 8; i++) begin
			cfg_index <= reg_idx_t'(i);
			cfg_data  <= next_coef[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		coef_sets++;
	endtask

	task automatic set_all_coefs(input logic [COEF_W-1:0] v);
		for (int i = 0; i < 8; i++)
			next_coef[i] = v;
	endtask

	// scan line with runs of one colour; noisy lines are random pixels and line starts
	task automatic send_scan_line(input int len, input bit noisy);
		logic [2:0] c;
		int run;
		run = 0;
		c = '0;
		for (int i = 0; i < len; i++) begin
			if (noisy) begin
				send_pixel(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
			end else begin
				if (run == 0) begin
					c = 3'($urandom_range(0, 7));
					run = $urandom_range(1, 12);
				end
				run--;
				send_pixel(c, i == 0 || $urandom_range(0, 49) == 0);
			end
		end
	endtask

	// every colour from a cleared history, then settled
	task automatic test_directed();
		for (int c = 0; c < 8; c++) begin
			send_pixel(3'(c), 1'b1);
			send_pixel(3'(c), 1'b0);
			send_pixel(3'(c), 1'b0);
		end
		drain();
	endtask

	// coefficient extremes drive the filters into saturation and the output clamps
	task automatic test_coef_extremes();
		for (int k = 0; k < 3; k++) begin
			case (k)
				0: set_all_coefs(COEF_MAX);
				1: set_all_coefs(COEF_MIN);
				default: begin
					set_all_coefs(COEF_MAX);
					next_coef[REG_LUMA_FB2]  = COEF_MIN;
					next_coef[REG_CHROMA_FB] = COEF_MIN;
					next_coef[REG_GREEN_BLUE] = COEF_MIN;
				end
			endcase
			load_coefs();
			send_pixel(3'd7, 1'b1);
			for (int i = 0; i < 5; i++) send_pixel(3'd7, 1'b0);
			for (int i = 0; i < 3; i++) send_pixel(3'd0, 1'b0);
			send_pixel(3'd5, 1'b0);
			send_pixel(3'd2, 1'b0);
			send_pixel(3'd7, 1'b1);
			drain();
		end
	endtask

	function automatic logic [COEF_W-1:0] pick_coef(input int kind, input int i);
		case (kind)
			0: return dflt_coef[i];
			1: return COEF_W'($urandom_range(0, 262143));
			2: return dflt_coef[i] + COEF_W'($urandom_range(0, 16383)) - COEF_W'(8192);
			default: begin
				case ($urandom_range(0, 3))
					0: return COEF_MAX;
					1: return COEF_MIN;
					2: return '0;
					default: return COEF_W'($urandom_range(0, 262143));
				endcase
			end
		endcase
	endfunction

	task automatic test_random_scan();
		int phase;
		int target;
		phase = 0;
		target = pixels_sent + RANDOM_PIXELS;
		while (pixels_sent < target) begin
			for (int i = 0; i < 8; i++)
				next_coef[i] = pick_coef(phase % 4, i);
			load_coefs();
			tx_idle_on = (phase % 3) != 1;
			rx_idle_on = (phase % 3) != 2;
			for (int n = 0; n < 150; n += 0) begin
				int len;
				len = $urandom_range(8, 48);
				send_scan_line(len, $urandom_range(0, 9) == 0);
				n += len;
			end
			drain();
			phase++;
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// long receiver hold-off while pixels keep coming, the block must stall its input
	task automatic test_backpressure();
		for (int i = 0; i < 8; i++)
			next_coef[i] = dflt_coef[i];
		load_coefs();
		tx_idle_on = 1'b0;
		rx_hold_len = 300;
		send_scan_line(40, 1'b0);
		drain();
		tx_idle_on = 1'b1;
	endtask

	initial begin
		dflt_coef[REG_LUMA_TAP0]   = RST_LUMA_TAP0;
		dflt_coef[REG_LUMA_TAP1]   = RST_LUMA_TAP1;
		dflt_coef[REG_LUMA_TAP2]   = RST_LUMA_TAP2;
		dflt_coef[REG_LUMA_FB2]    = RST_LUMA_FB2;
		dflt_coef[REG_CHROMA_GAIN] = RST_CHROMA_GAIN;
		dflt_coef[REG_CHROMA_FB]   = RST_CHROMA_FB;
		dflt_coef[REG_GREEN_RED]   = RST_GREEN_RED;
		dflt_coef[REG_GREEN_BLUE]  = RST_GREEN_BLUE;
		for (int i = 0; i < 8; i++)
			coef[i] = dflt_coef[i];
		clear_history();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_coef_extremes();
		test_random_scan();
		test_backpressure();
		// nothing more may come out
		repeat (40) @(posedge clk);
		$display("%0d pixels (%0d line starts) checked as %0d words", pixels_sent, line_starts,
			words_checked);
		$display("%0d coefficient sets loaded, extremes and one long output hold-off included",
			coef_sets);
		if (mismatches == 0 && expected_rgb_q.size() == 0) begin
			$display("[pal_colour_bleed_filter_core] OK");
		end else begin
			$display("%0d mismatches, %0d words missing", mismatches, expected_rgb_q.size());
			$display("[pal_colour_bleed_filter_core] ERROR");
		end
		$finish;
	end

endmodule
